@@ hdl/dcg_pkg.sv @@
// ----------------------------------------------------------------------------
// dcg_pkg
// Shared types, constants and table helpers of the damped cosine generator.
// ----------------------------------------------------------------------------
package dcg_pkg;

  // Default sizes handed to the top-level parameters
  localparam int COS_TABLE_BITS_DEF = 10;
  localparam int FRAME_BITS_DEF     = 24;

  // Fixed field widths
  localparam int PHASE_W  = 32;
  localparam int ENV_W    = 32;
  localparam int AMP_W    = 16;
  localparam int CNT_W    = 24;
  localparam int SAMPLE_W = 16;
  localparam int COS_W    = 16;
  localparam int MUL_W    = 32;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  // Run state lives in a single-entry memory
  localparam int STATE_DEPTH = 1;

  // Reset values
  localparam logic [ENV_W-1:0] ENV_ONE     = 32'h8000_0000;
  localparam logic [AMP_W-1:0] AMP_RESET   = 16'h8000;
  localparam logic [ENV_W-1:0] DECAY_RESET = 32'hFFFF_FFFF;

  // pi/2 in Q30 and the Taylor series divisors (2n-1)*2n
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 9;
  localparam int TAYLOR_DIV [TAYLOR_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_PHASE_INC    = 2'd0,
    CFG_AMPLITUDE    = 2'd1,
    CFG_DECAY        = 2'd2,
    CFG_SAMPLE_COUNT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_inc;
    logic [AMP_W-1:0]   amplitude;
    logic [ENV_W-1:0]   decay;
    logic [CNT_W-1:0]   count;
  } cfg_t;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_MUL_CA = 6'b000100,
    ST_MUL_CE = 6'b001000,
    ST_MUL_ED = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  // Operand pair of the shared multiplier
  typedef enum logic [1:0] {
    MUL_COS_AMP = 2'd0,
    MUL_ENV     = 2'd1,
    MUL_DECAY   = 2'd2
  } mul_sel_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic     start;
    logic     load_state;
    mul_sel_t mul_sel;
    logic     cap_sample;
    logic     commit;
  } ctl_t;

  // One Q1.15 quarter-wave cosine entry, evaluated at elaboration
  function automatic logic [COS_W-1:0] cos_entry(input int unsigned k,
                                                 input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = (HALF_PI_Q30 * 64'(k)) >> bits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
      if ((n & 1) == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    rnd = ($unsigned(sum) + 64'd16384) >> 15;
    return rnd[COS_W-1:0];
  endfunction

endpackage

@@ hdl/dcg_ram.sv @@
// ----------------------------------------------------------------------------
// dcg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcg_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/dcg_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcg_ctrl
// Sequencer: takes a tick, steps the shared multiplier, hands off the result.
// ----------------------------------------------------------------------------
module dcg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          run_done,
  output dcg_pkg::ctl_t ctl
);
  import dcg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Finish only when the output register is free or being emptied
  assign commit = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = run_done ? ST_IDLE : ST_MUL_CA;
      ST_MUL_CA: state_nxt = ST_MUL_CE;
      ST_MUL_CE: state_nxt = ST_MUL_ED;
      ST_MUL_ED: state_nxt = ST_FIN;
      ST_FIN:    if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on commit, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath controls; keep the envelope product alive while the result waits
  always_comb begin
    ctl.start      = in_valid && in_ready;
    ctl.load_state = (state_r == ST_READ);
    ctl.cap_sample = (state_r == ST_MUL_ED);
    ctl.commit     = commit;
    ctl.mul_sel    = MUL_COS_AMP;
    unique case (state_r)
      ST_MUL_CE:         ctl.mul_sel = MUL_ENV;
      ST_MUL_ED, ST_FIN: ctl.mul_sel = MUL_DECAY;
      default:           ctl.mul_sel = MUL_COS_AMP;
    endcase
  end

endmodule

@@ hdl/dcg_datapath.sv @@
// ----------------------------------------------------------------------------
// dcg_datapath
// Run-state memory, cosine table, shared multiplier and output register.
// ----------------------------------------------------------------------------
module dcg_datapath #(
  parameter int COS_TABLE_BITS = 10,
  parameter int FRAME_BITS     = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dcg_pkg::cfg_t                       cfg,
  input  logic                                in_restart,
  input  dcg_pkg::ctl_t                       ctl,
  output logic                                run_done,
  output logic signed [dcg_pkg::SAMPLE_W-1:0] out_sample,
  output logic [FRAME_BITS-1:0]               out_frame,
  output logic [dcg_pkg::SAMPLE_W-1:0]        out_peak_magnitude,
  output logic [FRAME_BITS-1:0]               out_peak_frame,
  output logic                                out_last
);
  import dcg_pkg::*;

  localparam int QLEN   = 1 << COS_TABLE_BITS;
  localparam int TAB_AW = COS_TABLE_BITS + 1;
  localparam int RAM_AW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
  localparam int CMP_W  = (FRAME_BITS + 1 > CNT_W) ? FRAME_BITS + 1 : CNT_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SCL_W  = PROD_W + 15;

  typedef struct packed {
    logic [PHASE_W-1:0]    phase;
    logic [ENV_W-1:0]      env;
    logic [FRAME_BITS-1:0] frame;
    logic [SAMPLE_W-1:0]   peak_val;
    logic [FRAME_BITS-1:0] peak_idx;
  } run_t;

  localparam int RUN_W = $bits(run_t);

  typedef logic [COS_W-1:0] cos_tab_t [QLEN+1];

  function automatic cos_tab_t build_tab();
    cos_tab_t t;
    for (int k = 0; k <= QLEN; k++) begin
      t[k] = cos_entry(k, COS_TABLE_BITS);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_tab();

  localparam run_t RUN_CLEAR = '{
    phase:    '0,
    env:      ENV_ONE,
    frame:    '0,
    peak_val: '0,
    peak_idx: '0
  };

  logic                  restart_r;
  logic                  st_valid_r;
  logic [RUN_W-1:0]      ram_rdata;
  logic                  ram_we;
  logic [RUN_W-1:0]      ram_wdata;
  run_t                  cur;
  run_t                  st_r;
  run_t                  nxt;
  logic [COS_TABLE_BITS-1:0] tab_idx;
  logic [TAB_AW-1:0]     tab_addr;
  logic [COS_W-1:0]      cos_q_r;
  logic                  neg_r;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     prod_r;
  logic [SCL_W-1:0]      scaled;
  logic [17:0]           raw_mag;
  logic [SAMPLE_W-1:0]   sat_mag;
  logic [SAMPLE_W-1:0]   mag_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [CMP_W-1:0]      frame_ext, count_ext;

  // Latch the restart flag with the tick
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      restart_r <= in_restart;
    end
  end

  // Run state memory; the sequencer never overlaps a write with the next read
  dcg_ram #(
    .WIDTH (RUN_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (RAM_AW'(0)),
    .wdata (ram_wdata),
    .re    (ctl.start),
    .raddr (RAM_AW'(0)),
    .rdata (ram_rdata)
  );

  // Entry counts as cleared until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (ram_we) begin
      st_valid_r <= 1'b1;
    end
  end

  // Resolve the state seen by this tick
  assign cur       = (restart_r || !st_valid_r) ? RUN_CLEAR : run_t'(ram_rdata);
  assign frame_ext = CMP_W'(cur.frame);
  assign count_ext = CMP_W'(cfg.count);
  assign run_done  = (frame_ext >= count_ext);

  // Write back the resolved state on a finished count, else the advanced one
  assign ram_we    = (ctl.load_state && run_done) || ctl.commit;
  assign ram_wdata = ctl.load_state ? RUN_W'(cur) : RUN_W'(nxt);

  // Quarter-wave table address
  assign tab_idx  = cur.phase[PHASE_W-3 -: COS_TABLE_BITS];
  assign tab_addr = cur.phase[PHASE_W-2] ? (TAB_AW'(QLEN) - TAB_AW'(tab_idx))
                                         : TAB_AW'(tab_idx);

  // Hold the state and read the table
  always_ff @(posedge clk) begin
    if (ctl.load_state) begin
      st_r    <= cur;
      cos_q_r <= COS_TAB[tab_addr];
    end
  end

  // Sign of the cosine, known once the table entry is in
  always_ff @(posedge clk) begin
    if (ctl.mul_sel == MUL_COS_AMP) begin
      neg_r <= (st_r.phase[PHASE_W-1] ^ st_r.phase[PHASE_W-2]) && (cos_q_r != '0);
    end
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = MUL_W'(cos_q_r);
    mul_b = MUL_W'(cfg.amplitude);
    unique case (ctl.mul_sel)
      MUL_COS_AMP: begin
        mul_a = MUL_W'(cos_q_r);
        mul_b = MUL_W'(cfg.amplitude);
      end
      MUL_ENV: begin
        mul_a = prod_r[MUL_W-1:0];
        mul_b = st_r.env;
      end
      MUL_DECAY: begin
        mul_a = st_r.env;
        mul_b = cfg.decay;
      end
      default: begin
        mul_a = MUL_W'(cos_q_r);
        mul_b = MUL_W'(cfg.amplitude);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Scale by 32767, drop 61 fraction bits, saturate
  assign scaled  = {prod_r, 15'd0} - SCL_W'(prod_r);
  assign raw_mag = scaled[SCL_W-1 -: 18];

  always_comb begin
    if (neg_r) begin
      sat_mag = (raw_mag > 18'd32768) ? 16'h8000 : raw_mag[SAMPLE_W-1:0];
    end else begin
      sat_mag = (raw_mag > 18'd32767) ? 16'h7FFF : raw_mag[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_sample) begin
      mag_r    <= sat_mag;
      sample_r <= neg_r ? $signed(16'd0 - sat_mag) : $signed(sat_mag);
    end
  end

  // Advance phase, envelope and frame; update the peak
  always_comb begin
    nxt       = st_r;
    nxt.phase = st_r.phase + cfg.phase_inc;
    nxt.env   = prod_r[PROD_W-1 -: ENV_W];
    nxt.frame = st_r.frame + FRAME_BITS'(1);
    if (mag_r > st_r.peak_val) begin
      nxt.peak_val = mag_r;
      nxt.peak_idx = st_r.frame;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_sample         <= sample_r;
      out_frame          <= st_r.frame;
      out_peak_magnitude <= nxt.peak_val;
      out_peak_frame     <= nxt.peak_idx;
      out_last           <= ((CMP_W'(st_r.frame) + CMP_W'(1)) == count_ext);
    end
  end

endmodule

@@ hdl/damped_cosine_generator_top.sv @@
// ----------------------------------------------------------------------------
// damped_cosine_generator_top
// Decaying cosine tone generator with peak tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the in_ channel is one tick. While the frame counter is
//   below sample_count the tick yields one sample on the out_ channel, with
//   its frame index, the running peak magnitude and its first frame, and a
//   last flag on the final sample. Later ticks yield nothing. in_restart
//   clears phase, envelope, frame and peak before the tick is processed.
//   Registers are written through cfg_we/cfg_addr/cfg_wdata while idle.
// Sequence:
//   A producing tick takes one state memory read followed by three passes
//   through the shared 32x32 multiplier (cosine x amplitude, x envelope,
//   envelope x decay); the input reopens once its result is committed to
//   the output register, so one tick is processed at a time.
//   A tick past the count frees the input after the state memory read.
// Reset and stall:
//   rst_n restores the register defaults and marks the run state cleared.
//   A finished sample waits in the output register; the next tick is still
//   taken, and its result holds until the register empties.
// ----------------------------------------------------------------------------
module damped_cosine_generator_top #(
  parameter int COS_TABLE_BITS = dcg_pkg::COS_TABLE_BITS_DEF,
  parameter int FRAME_BITS     = dcg_pkg::FRAME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dcg_pkg::SAMPLE_W-1:0] out_sample,
  output logic [FRAME_BITS-1:0]               out_frame,
  output logic [dcg_pkg::SAMPLE_W-1:0]        out_peak_magnitude,
  output logic [FRAME_BITS-1:0]               out_peak_frame,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [dcg_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [dcg_pkg::CFG_DW-1:0]          cfg_wdata
);
  import dcg_pkg::*;

  cfg_t cfg_r;
  ctl_t ctl;
  logic run_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_inc <= '0;
      cfg_r.amplitude <= AMP_RESET;
      cfg_r.decay     <= DECAY_RESET;
      cfg_r.count     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PHASE_INC:    cfg_r.phase_inc <= cfg_wdata[PHASE_W-1:0];
        CFG_AMPLITUDE:    cfg_r.amplitude <= cfg_wdata[AMP_W-1:0];
        CFG_DECAY:        cfg_r.decay     <= cfg_wdata[ENV_W-1:0];
        CFG_SAMPLE_COUNT: cfg_r.count     <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  dcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_done  (run_done),
    .ctl       (ctl)
  );

  dcg_datapath #(
    .COS_TABLE_BITS (COS_TABLE_BITS),
    .FRAME_BITS     (FRAME_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_restart         (in_restart),
    .ctl                (ctl),
    .run_done           (run_done),
    .out_sample         (out_sample),
    .out_frame          (out_frame),
    .out_peak_magnitude (out_peak_magnitude),
    .out_peak_frame     (out_peak_frame),
    .out_last           (out_last)
  );

endmodule

@@ hdl/dcg_checker.sv @@
// ----------------------------------------------------------------------------
// dcg_checker
// Port-level assertions for the damped cosine generator, bound to the top.
// ----------------------------------------------------------------------------
module dcg_checker #(
  parameter int FRAME_BITS = dcg_pkg::FRAME_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dcg_pkg::SAMPLE_W-1:0] out_sample,
  input logic [FRAME_BITS-1:0]               out_frame,
  input logic [dcg_pkg::SAMPLE_W-1:0]        out_peak_magnitude,
  input logic [FRAME_BITS-1:0]               out_peak_frame,
  input logic                                out_last
);
  import dcg_pkg::*;

  logic [SAMPLE_W:0] sample_mag;
  logic              in_xfer;
  logic              out_stall;

  assign sample_mag = out_sample[SAMPLE_W-1]
                    ? ((SAMPLE_W+1)'(0) - {out_sample[SAMPLE_W-1], out_sample})
                    : {1'b0, out_sample};
  assign in_xfer    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;

  // One tick at a time: input closes right after a transfer
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while a tick is in progress");

  // A new result appears only at the end of a tick's processing
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without a tick in progress");

  // Peak covers the sample it is reported with
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_peak_magnitude} >= sample_mag))
    else $error("peak magnitude below current sample");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_stall |=> out_valid && $stable(out_sample) && $stable(out_frame)
                  && $stable(out_peak_magnitude) && $stable(out_peak_frame)
                  && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind damped_cosine_generator_top dcg_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_dcg_checker (.*);
